### rtl/core/ppsc_pkg.sv
// Shared widths and constant functions for the point projection core.
`default_nettype none

package ppsc_pkg;

  // Screen divide: 64-bit numerator, 50-bit divisor, 31-bit Q15.16 quotient
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 50;
  localparam int QUO_W     = 31;
  localparam int FRAC_BITS = 16;

  // Exp2 fraction chain: one multiply per fraction bit
  localparam int EXP_STEPS = 16;
  localparam int ROOT_W    = 31;

  function automatic logic [63:0] isqrt_f(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bitv;
    n = n_in;
    r = 64'd0;
    for (int j = 31; j >= 0; j--) begin
      bitv = 64'd1 << (2 * j);
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Q1.30 value of 2^(2^-(k+1))
  function automatic logic [ROOT_W-1:0] pow_root_f(input int k);
    logic [63:0] p;
    p = isqrt_f(64'd2 << 60);
    for (int j = 1; j <= k; j++) begin
      p = isqrt_f(p << 30);
    end
    return ROOT_W'(p);
  endfunction

endpackage

`default_nettype wire

### rtl/core/ppsc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module ppsc_div import ppsc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      // numerator is num * 2^16; quotient fits QUO_W bits, so start from its top part
      assign rem_in = DEN_W'(num_i >> (QUO_W - FRAC_BITS));
      assign low_in = QUO_W'({num_i, FRAC_BITS'(0)});
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
        low_q[s] <= low_in << 1;
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

### rtl/core/ppsc_exp2.sv
// Pipelined exp2 of a 16-bit fraction as a product of root-of-two factors.
`default_nettype none

module ppsc_exp2 import ppsc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [FRAC_BITS-1:0]   frac_i,
  output logic      [ROOT_W-1:0]      m_o
);

  logic [ROOT_W-1:0]    m_q [EXP_STEPS];
  logic [FRAC_BITS-1:0] f_q [EXP_STEPS];

  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_step
    localparam logic [ROOT_W-1:0] ROOT = pow_root_f(k);
    logic [ROOT_W-1:0]    m_in;
    logic [FRAC_BITS-1:0] f_in;
    logic [2*ROOT_W-1:0]  prod;

    if (k == 0) begin : g_first
      assign m_in = ROOT_W'(64'd1 << 30);
      assign f_in = frac_i;
    end else begin : g_next
      assign m_in = m_q[k-1];
      assign f_in = f_q[k-1];
    end

    assign prod = (2*ROOT_W)'(m_in) * (2*ROOT_W)'(ROOT);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k] <= f_in[FRAC_BITS-1-k] ? prod[30 +: ROOT_W] : m_in;
        f_q[k] <= f_in;
      end
    end
  end

  assign m_o = m_q[EXP_STEPS-1];

endmodule

`default_nettype wire

### rtl/core/point_projection_screen_cull.sv
// Throughput: one point per cycle; the screen divide (31 stages, one bit each)
// sets the depth. The whole pipeline holds while a result waits untaken.
// Reset: clears all stage valid bits and loads the identity matrix, a
// 1920x1080 viewport, unit reference depth and unit exponent.
`default_nettype none

module point_projection_screen_cull_core import ppsc_pkg::*; #(
  parameter int MIN_SCALE       = 128,
  parameter int MAX_SCALE       = 512,
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] world_x_i,
  input  wire logic signed [31:0] world_y_i,
  input  wire logic signed [31:0] world_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    visible_o,
  output logic signed [31:0]      screen_x_o,
  output logic signed [31:0]      screen_y_o,
  output logic        [30:0]      view_depth_o,
  output logic        [15:0]      depth_scale_o
);

  localparam logic [2:0] REG_ROW_X  = 3'd0;
  localparam logic [2:0] REG_ROW_Y  = 3'd1;
  localparam logic [2:0] REG_ROW_Z  = 3'd2;
  localparam logic [2:0] REG_ROW_W  = 3'd3;
  localparam logic [2:0] REG_VP_W   = 3'd4;
  localparam logic [2:0] REG_VP_H   = 3'd5;
  localparam logic [2:0] REG_REF    = 3'd6;
  localparam logic [2:0] REG_DAMP   = 3'd7;

  localparam int CLIP_W   = 50;
  localparam int LOGV_W   = 42;
  localparam int IDX_W    = $clog2(LOG_TABLE_DEPTH);
  localparam int STAGES   = 36;
  localparam int SIDE_DLY = QUO_W;
  localparam int SC_DLY   = 9;

  typedef struct packed {
    logic        vis;
    logic        negx;
    logic        negy;
    logic [30:0] depth;
  } side_t;

  typedef struct packed {
    logic       zero;
    logic       sat;
    logic [3:0] n;
  } expf_t;

  function automatic logic [15:0] log_frac_f(input int idx);
    logic [63:0] x;
    logic [15:0] fr;
    x  = (64'd1 << 30) + ((64'(idx) << 30) / LOG_TABLE_DEPTH);
    fr = '0;
    for (int b = 15; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        fr[b] = 1'b1;
        x     = x >> 1;
      end
    end
    return fr;
  endfunction

  function automatic logic [5:0] msb_f(input logic [LOGV_W-1:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < LOGV_W; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  logic [15:0] log_tab [LOG_TABLE_DEPTH];
  for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_tab
    assign log_tab[gi] = log_frac_f(gi);
  end

  // configuration
  logic [63:0] row_x_q, row_y_q, row_w_q;
  logic [13:0] vp_w_q, vp_h_q;
  logic [30:0] ref_q;
  logic [14:0] damp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q <= 64'd256;
      row_y_q <= 64'd16777216;
      row_w_q <= 64'd72057594037927936;
      vp_w_q  <= 14'd1920;
      vp_h_q  <= 14'd1080;
      ref_q   <= 31'd65536;
      damp_q  <= 15'd16384;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW_X: row_x_q <= cfg_data_i;
        REG_ROW_Y: row_y_q <= cfg_data_i;
        // clip z feeds nothing downstream; drop the write
        REG_ROW_Z: ;
        REG_ROW_W: row_w_q <= cfg_data_i;
        REG_VP_W:  vp_w_q  <= cfg_data_i[13:0];
        REG_VP_H:  vp_h_q  <= cfg_data_i[13:0];
        REG_REF:   ref_q   <= cfg_data_i[30:0];
        REG_DAMP:  damp_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // pipeline control: all stages advance together
  logic [STAGES-1:0] v_q;
  logic              adv;

  assign adv         = !v_q[STAGES-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[STAGES-2:0], in_valid_i};
    end
  end

  // stage 1: lane products; clip z row is not needed
  logic [63:0]        rows [3];
  logic signed [31:0] world [3];
  logic signed [47:0] p_q [3][3];
  logic signed [15:0] c3_q [3];

  assign rows[0]  = row_x_q;
  assign rows[1]  = row_y_q;
  assign rows[2]  = row_w_q;
  assign world[0] = world_x_i;
  assign world[1] = world_y_i;
  assign world[2] = world_z_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          p_q[r][k] <= $signed(rows[r][16*k +: 16]) * world[k];
        end
        c3_q[r] <= $signed(rows[r][63:48]);
      end
    end
  end

  // stage 2: clip coordinates in Q26.24
  logic signed [CLIP_W-1:0] clip_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        clip_q[r] <= CLIP_W'(p_q[r][0]) + CLIP_W'(p_q[r][1]) + CLIP_W'(p_q[r][2])
                   + (CLIP_W'(c3_q[r]) <<< 16);
      end
    end
  end

  // stage 3: cull and screen numerators
  logic signed [CLIP_W+3:0] fx_d, fy_d, lim_d;
  logic signed [CLIP_W:0]   tx_d, ty_d, ax_d, ay_d;
  logic                     vis_d;

  always_comb begin
    fx_d  = ((CLIP_W+4)'(clip_q[0]) <<< 2) + (CLIP_W+4)'(clip_q[0]);
    fy_d  = ((CLIP_W+4)'(clip_q[1]) <<< 2) + (CLIP_W+4)'(clip_q[1]);
    lim_d = ((CLIP_W+4)'(clip_q[2]) <<< 2) + ((CLIP_W+4)'(clip_q[2]) <<< 1);
    vis_d = (clip_q[2] >= CLIP_W'(1792)) && (fx_d <= lim_d) && (fx_d >= -lim_d)
         && (fy_d <= lim_d) && (fy_d >= -lim_d);
    tx_d  = (CLIP_W+1)'(clip_q[0]) + (CLIP_W+1)'(clip_q[2]);
    ty_d  = (CLIP_W+1)'(clip_q[2]) - (CLIP_W+1)'(clip_q[1]);
    ax_d  = tx_d[CLIP_W] ? -tx_d : tx_d;
    ay_d  = ty_d[CLIP_W] ? -ty_d : ty_d;
  end

  logic                vis3_q, negx3_q, negy3_q;
  logic [CLIP_W-1:0]   magx3_q, magy3_q;
  logic [DEN_W-1:0]    den3_q;
  logic [LOGV_W-1:0]   w16_3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis3_q  <= vis_d;
      negx3_q <= tx_d[CLIP_W];
      negy3_q <= ty_d[CLIP_W];
      magx3_q <= ax_d[CLIP_W-1:0];
      magy3_q <= ay_d[CLIP_W-1:0];
      den3_q  <= DEN_W'({clip_q[2], 1'b0});
      w16_3_q <= LOGV_W'(clip_q[2] >>> 8);
    end
  end

  // stage 4: numerators, depth floor, leading-one positions
  logic [NUM_W-1:0]  numx4_q, numy4_q;
  logic [DEN_W-1:0]  den4_q;
  side_t             side4_q;
  logic [LOGV_W-1:0] d4_q, r4_q;
  logic [5:0]        pd4_q, pr4_q;
  logic [LOGV_W-1:0] dfl_d, rfl_d;

  assign dfl_d = (w16_3_q > LOGV_W'(66)) ? w16_3_q : LOGV_W'(66);
  assign rfl_d = (ref_q == '0) ? LOGV_W'(1) : LOGV_W'(ref_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx4_q       <= NUM_W'(magx3_q) * NUM_W'(vp_w_q);
      numy4_q       <= NUM_W'(magy3_q) * NUM_W'(vp_h_q);
      den4_q        <= den3_q;
      side4_q.vis   <= vis3_q;
      side4_q.negx  <= negx3_q;
      side4_q.negy  <= negy3_q;
      side4_q.depth <= (w16_3_q > LOGV_W'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : w16_3_q[30:0];
      d4_q          <= dfl_d;
      r4_q          <= rfl_d;
      pd4_q         <= msb_f(dfl_d);
      pr4_q         <= msb_f(rfl_d);
    end
  end

  // stage 5: normalize so the leading one drops off the top
  logic [LOGV_W-2:0] fd5_q, fr5_q;
  logic [5:0]        pd5_q, pr5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fd5_q <= (LOGV_W-1)'(d4_q << (6'(LOGV_W-1) - pd4_q));
      fr5_q <= (LOGV_W-1)'(r4_q << (6'(LOGV_W-1) - pr4_q));
      pd5_q <= pd4_q;
      pr5_q <= pr4_q;
    end
  end

  // stage 6: table index = floor(fraction * depth)
  logic [LOGV_W+IDX_W-1:0] ipd_d, ipr_d;
  logic [IDX_W-1:0]        id6_q, ir6_q;
  logic [5:0]              pd6_q, pr6_q;

  assign ipd_d = (LOGV_W+IDX_W)'(fd5_q) * (LOGV_W+IDX_W)'(LOG_TABLE_DEPTH);
  assign ipr_d = (LOGV_W+IDX_W)'(fr5_q) * (LOGV_W+IDX_W)'(LOG_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      id6_q <= ipd_d[LOGV_W-1 +: IDX_W];
      ir6_q <= ipr_d[LOGV_W-1 +: IDX_W];
      pd6_q <= pd5_q;
      pr6_q <= pr5_q;
    end
  end

  // stage 7: log2 in Q.16
  logic [21:0] ld7_q, lr7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ld7_q <= {pd6_q, log_tab[id6_q]};
      lr7_q <= {pr6_q, log_tab[ir6_q]};
    end
  end

  // stage 8: scaled log difference
  logic signed [22:0] diff_d;
  logic signed [38:0] prod8_q;

  assign diff_d = $signed({1'b0, lr7_q}) - $signed({1'b0, ld7_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod8_q <= 39'(diff_d) * $signed(39'({1'b0, damp_q}));
    end
  end

  // stage 9: exponent, floored, biased by 8.0 for the Q8.8 result
  logic signed [25:0] e_d;
  expf_t              ef9_q;
  logic [15:0]        efr9_q;

  assign e_d = 26'(prod8_q >>> 14) + 26'sd524288;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ef9_q.zero <= e_d[25];
      ef9_q.sat  <= !e_d[25] && (e_d[24:20] != '0);
      ef9_q.n    <= e_d[19:16];
      efr9_q     <= e_d[15:0];
    end
  end

  // stages 10..25: exp2 fraction chain
  logic [ROOT_W-1:0] m25;
  expf_t             ef_q [EXP_STEPS];

  ppsc_exp2 u_exp2 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .frac_i (efr9_q),
    .m_o    (m25)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ef_q[0] <= ef9_q;
      for (int i = 1; i < EXP_STEPS; i++) ef_q[i] <= ef_q[i-1];
    end
  end

  // stage 26: integer shift, saturate, clamp
  logic [15:0] vs_d, vc_d;
  expf_t       ef25;

  assign ef25 = ef_q[EXP_STEPS-1];

  always_comb begin
    vs_d = 16'(m25 >> (5'd30 - {1'b0, ef25.n}));
    if (ef25.zero) vs_d = '0;
    else if (ef25.sat) vs_d = 16'hFFFF;
    vc_d = vs_d;
    if (vc_d > 16'(MAX_SCALE)) vc_d = 16'(MAX_SCALE);
    if (vc_d < 16'(MIN_SCALE)) vc_d = 16'(MIN_SCALE);
  end

  logic [15:0] sc26_q;
  logic [15:0] sc_q [SC_DLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc26_q <= vc_d;
      sc_q[0] <= sc26_q;
      for (int i = 1; i < SC_DLY; i++) sc_q[i] <= sc_q[i-1];
    end
  end

  // stages 5..35: screen divides, with side data held alongside
  logic [QUO_W-1:0] qx35, qy35;
  side_t            side_q [SIDE_DLY];

  ppsc_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numx4_q),
    .den_i (den4_q),
    .quo_o (qx35)
  );

  ppsc_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numy4_q),
    .den_i (den4_q),
    .quo_o (qy35)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side4_q;
      for (int i = 1; i < SIDE_DLY; i++) side_q[i] <= side_q[i-1];
    end
  end

  // stage 36: output register; invisible points read all zero
  side_t side35;

  assign side35 = side_q[SIDE_DLY-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      visible_o     <= side35.vis;
      screen_x_o    <= !side35.vis ? '0 :
                       side35.negx ? 32'd0 - 32'(qx35) : 32'(qx35);
      screen_y_o    <= !side35.vis ? '0 :
                       side35.negy ? 32'd0 - 32'(qy35) : 32'(qy35);
      view_depth_o  <= side35.vis ? side35.depth : '0;
      depth_scale_o <= side35.vis ? sc_q[SC_DLY-1] : '0;
    end
  end

endmodule

`default_nettype wire
